@@ sv/pdc_pkg.sv @@
// Shared types and constants of the perspective depth converter.
`default_nettype none
package pdc_pkg;
	localparam int COORD_BITS_DEF = 12;
	localparam int DEPTH_W = 32;
	localparam int FRAME_W = 13;
	localparam int PLANE_W = 24;
	localparam int LEN_W = 20;
	localparam int NORM_W = 24;
	localparam int ROOT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [NORM_W-1:0] DEPTH_FULL = '1;
	localparam logic [DEPTH_W-1:0] WORD_MAX = '1;

	// Reset values of the configuration registers
	localparam logic [DEPTH_W-1:0] NEAR_RST = 32'd65536;
	localparam logic [DEPTH_W-1:0] FAR_RST = 32'd65536000;
	localparam logic [PLANE_W-1:0] PLANE_RST = 24'd131072;
	localparam logic [LEN_W-1:0] DLS_RST = 20'd65536;
	localparam logic [FRAME_W-1:0] FRAME_RST = 13'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_NEAR,
		CFG_FAR,
		CFG_PSX,
		CFG_PSY,
		CFG_DLS,
		CFG_FW,
		CFG_FH
	} cfg_idx_t;
endpackage
`default_nettype wire

@@ sv/pdc_if.sv @@
// Channel interfaces: pixel input, depth result and configuration write.
`default_nettype none
interface pdc_pix_if import pdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [DEPTH_W-1:0] depth_in;
	modport source(output valid, pixel_x, pixel_y, depth_in, input ready);
	modport sink(input valid, pixel_x, pixel_y, depth_in, output ready);
endinterface

interface pdc_res_if import pdc_pkg::*;;
	logic valid;
	logic ready;
	logic [DEPTH_W-1:0] depth_out;
	logic saturated;
	modport source(output valid, depth_out, saturated, input ready);
	modport sink(input valid, depth_out, saturated, output ready);
endinterface

interface pdc_cfg_if import pdc_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/pdc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none
module pdc_div #(
	parameter int DW = 64,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input wire clk,
	input wire arst_n,
	input wire en,
	input wire in_valid,
	input wire [DW-1:0] in_rem,
	input wire [DW-1:0] in_den,
	input wire [QW-1:0] in_lo,
	input wire [SW-1:0] in_side,
	output logic out_valid,
	output logic [QW-1:0] out_quot,
	output logic [SW-1:0] out_side
);
	logic v_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] acc_s [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic v_i;
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] acc_i;
		logic [SW-1:0] side_i;
		logic [DW:0] trial;
		logic ge;

		if (k == 0) begin : g_head
			assign v_i = in_valid;
			assign rem_i = in_rem;
			assign den_i = in_den;
			assign acc_i = in_lo;
			assign side_i = in_side;
		end else begin : g_body
			assign v_i = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign acc_i = acc_s[k-1];
			assign side_i = side_s[k-1];
		end

		// Shift in the next dividend bit and try a subtract
		assign trial = {rem_i, acc_i[QW-1]};
		assign ge = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
				acc_s[k] <= {acc_i[QW-2:0], ge};
				den_s[k] <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quot = acc_s[QW-1];
	assign out_side = side_s[QW-1];
endmodule
`default_nettype wire

@@ sv/perspective_depth_converter.sv @@
// Top level of the perspective depth converter: depth to ray distance and back.
//
//   channel  dir  payload                          transfer when
//   pixel    in   pixel_x, pixel_y, depth_in       pixel.valid && pixel.ready
//   result   out  depth_out, saturated             result.valid && result.ready
//   cfg      in   index, data                      cfg.valid (ready is always high)
//
// One pixel per cycle while the skid register is empty; the pipeline holds four units
// that work one bit per stage (pixel offset divide, square root, linear depth divide, final divide).
// Reset clears all valid bits and loads the register defaults; after a register write
// the derived near/far terms settle through the nf_q and then the nfm_q register.
// The pipeline freezes only while the skid register holds a result; input ready
// is the skid register being empty, so nothing is dropped or repeated.
`default_nettype none
module perspective_depth_converter import pdc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	pdc_pix_if.sink pixel,
	pdc_res_if.source result,
	pdc_cfg_if.sink cfg
);
	localparam int SPAN_W = FRAME_W;
	localparam int PIX_W = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;
	localparam int QA_W = PLANE_W + 7;
	localparam int NUMA_W = SPAN_W + QA_W;
	localparam int SQ_W = 2 * QA_W;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int P_W = DEPTH_W + NORM_W;
	localparam int NUM_W = RAD_W + NORM_W;

	// Configuration registers
	logic mode_q;
	logic [DEPTH_W-1:0] near_q, far_q;
	logic [PLANE_W-1:0] psx_q, psy_q;
	logic [LEN_W-1:0] dls_q;
	logic [FRAME_W-1:0] fw_q, fh_q;
	logic [RAD_W-1:0] nf_q;
	logic [NUM_W-1:0] nfm_q;
	logic [DEPTH_W-1:0] fmn_q;
	logic [SPAN_W-1:0] span_x, span_y;
	logic fgtn, feqn;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			near_q <= NEAR_RST;
			far_q <= FAR_RST;
			psx_q <= PLANE_RST;
			psy_q <= PLANE_RST;
			dls_q <= DLS_RST;
			fw_q <= FRAME_RST;
			fh_q <= FRAME_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_MODE: mode_q <= cfg.data[0];
				CFG_NEAR: near_q <= cfg.data[DEPTH_W-1:0];
				CFG_FAR: far_q <= cfg.data[DEPTH_W-1:0];
				CFG_PSX: psx_q <= cfg.data[PLANE_W-1:0];
				CFG_PSY: psy_q <= cfg.data[PLANE_W-1:0];
				CFG_DLS: dls_q <= cfg.data[LEN_W-1:0];
				CFG_FW: fw_q <= cfg.data[FRAME_W-1:0];
				CFG_FH: fh_q <= cfg.data[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	// Derive near/far products from the registers
	always_ff @(posedge clk) begin
		nf_q <= RAD_W'(near_q) * RAD_W'(far_q);
		nfm_q <= {nf_q, {NORM_W{1'b0}}} - NUM_W'(nf_q);
		fmn_q <= (far_q >= near_q) ? far_q - near_q : near_q - far_q;
	end

	assign span_x = (fw_q < FRAME_W'(2)) ? SPAN_W'(1) : fw_q - SPAN_W'(1);
	assign span_y = (fh_q < FRAME_W'(2)) ? SPAN_W'(1) : fh_q - SPAN_W'(1);
	assign fgtn = far_q > near_q;
	assign feqn = far_q == near_q;

	// Pipeline advance: freeze while the skid register is occupied
	logic en;
	logic skid_v_q;
	assign en = !skid_v_q;
	assign pixel.ready = en;

	function automatic logic [SPAN_W-1:0] axis_mag(input logic [PIX_W-1:0] pix,
			input logic [SPAN_W-1:0] span);
		logic [SPAN_W-1:0] pc;
		logic [SPAN_W:0] twice;
		pc = (pix > PIX_W'(span)) ? span : pix[SPAN_W-1:0];
		twice = {pc, 1'b0};
		return (twice >= {1'b0, span}) ? SPAN_W'(twice - {1'b0, span})
			: SPAN_W'({1'b0, span} - twice);
	endfunction

	// s1: distance of the pixel from the frame center, in half pixels
	logic v_s1;
	logic [SPAN_W-1:0] magx_s1, magy_s1;
	logic [DEPTH_W-1:0] depth_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= pixel.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s1 <= axis_mag(PIX_W'(pixel.pixel_x), span_x);
			magy_s1 <= axis_mag(PIX_W'(pixel.pixel_y), span_y);
			depth_s1 <= pixel.depth_in;
		end
	end

	// s2: offset numerators with rounding term
	logic v_s2;
	logic [NUMA_W-1:0] numx_s2, numy_s2;
	logic [DEPTH_W-1:0] depth_s2;
	logic [NUMA_W-8:0] prodx, prody;

	assign prodx = (NUMA_W-7)'(magx_s1) * (NUMA_W-7)'(psx_q);
	assign prody = (NUMA_W-7)'(magy_s1) * (NUMA_W-7)'(psy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2 <= {prodx, 7'b0} + NUMA_W'(span_x >> 1);
			numy_s2 <= {prody, 7'b0} + NUMA_W'(span_y >> 1);
			depth_s2 <= depth_s1;
		end
	end

	// Offset divide per axis; each carries half of the depth word
	logic vx_d, vy_d;
	logic [QA_W-1:0] ox_d, oy_d;
	logic [DEPTH_W/2-1:0] dhi_d, dlo_d;

	pdc_div #(.DW(SPAN_W), .QW(QA_W), .SW(DEPTH_W/2)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.in_rem(numx_s2[NUMA_W-1:QA_W]), .in_den(span_x), .in_lo(numx_s2[QA_W-1:0]),
		.in_side(depth_s2[DEPTH_W-1:DEPTH_W/2]),
		.out_valid(vx_d), .out_quot(ox_d), .out_side(dhi_d)
	);

	pdc_div #(.DW(SPAN_W), .QW(QA_W), .SW(DEPTH_W/2)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.in_rem(numy_s2[NUMA_W-1:QA_W]), .in_den(span_y), .in_lo(numy_s2[QA_W-1:0]),
		.in_side(depth_s2[DEPTH_W/2-1:0]),
		.out_valid(vy_d), .out_quot(oy_d), .out_side(dlo_d)
	);

	// s3: square the offsets
	logic v_s3;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;
	logic [DEPTH_W-1:0] depth_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= vx_d && vy_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= SQ_W'(ox_d) * SQ_W'(ox_d);
			sqy_s3 <= SQ_W'(oy_d) * SQ_W'(oy_d);
			depth_s3 <= {dhi_d, dlo_d};
		end
	end

	// s4: squared ray length
	logic v_s4;
	logic [RAD_W-1:0] rad_s4;
	logic [DEPTH_W-1:0] depth_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= RAD_W'({dls_q, 32'b0}) + RAD_W'(sqx_s3) + RAD_W'(sqy_s3);
			depth_s4 <= depth_s3;
		end
	end

	// Square root, one result bit per stage from the top
	logic sqv_s [ROOT_W];
	logic [ROOT_W-1:0] rt_s [ROOT_W];
	logic [RAD_W-1:0] srem_s [ROOT_W];
	logic [DEPTH_W-1:0] sqd_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic v_i;
		logic [ROOT_W-1:0] rt_i;
		logic [RAD_W-1:0] rem_i;
		logic [DEPTH_W-1:0] d_i;
		logic [RAD_W+1:0] delta;
		logic ge;

		if (k == 0) begin : g_head
			assign v_i = v_s4;
			assign rt_i = '0;
			assign rem_i = rad_s4;
			assign d_i = depth_s4;
		end else begin : g_body
			assign v_i = sqv_s[k-1];
			assign rt_i = rt_s[k-1];
			assign rem_i = srem_s[k-1];
			assign d_i = sqd_s[k-1];
		end

		// Growth of the square when this bit is set
		assign delta = ((RAD_W+2)'(rt_i) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
		assign ge = {2'b0, rem_i} >= delta;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[k] <= 1'b0;
			else if (en)
				sqv_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k] <= ge ? (rt_i | (ROOT_W'(1) << B)) : rt_i;
				srem_s[k] <= ge ? rem_i - delta[RAD_W-1:0] : rem_i;
				sqd_s[k] <= d_i;
			end
		end
	end

	// s5: first products (mode 0 denominator terms, mode 1 distance times length)
	logic v_s5;
	logic [P_W-1:0] p1_s5, p2_s5;
	logic [ROOT_W-1:0] r_s5;
	logic [DEPTH_W-1:0] ma5;
	logic [NORM_W-1:0] mb5, x5;

	assign x5 = sqd_s[ROOT_W-1][NORM_W-1:0];
	assign ma5 = mode_q ? sqd_s[ROOT_W-1] : far_q;
	assign mb5 = mode_q ? NORM_W'(dls_q) : DEPTH_FULL - x5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= sqv_s[ROOT_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s5 <= P_W'(ma5) * P_W'(mb5);
			p2_s5 <= P_W'(near_q) * P_W'(x5);
			r_s5 <= rt_s[ROOT_W-1];
		end
	end

	// s6: divisor, mode 1 numerator, zero divisor check
	logic v_s6, zd_s6;
	logic [RAD_W-1:0] den_s6;
	logic [NUM_W-1:0] numa_s6;
	logic [ROOT_W-1:0] r_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= mode_q ? RAD_W'(r_s5) : RAD_W'(p1_s5) + RAD_W'(p2_s5);
			numa_s6 <= NUM_W'({p1_s5, 8'b0}) + NUM_W'(r_s5 >> 1);
			zd_s6 <= mode_q ? (r_s5 == '0)
				: ((p1_s5 == '0) && (p2_s5 == '0)) || (dls_q == '0);
			r_s6 <= r_s5;
		end
	end

	// s7: numerator of the linear depth divide
	logic v_s7, zd_s7;
	logic [NUM_W-1:0] num1_s7;
	logic [RAD_W-1:0] den1_s7;
	logic [ROOT_W-1:0] r_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s7 <= mode_q ? numa_s6 : nfm_q + NUM_W'(den_s6 >> 1);
			den1_s7 <= den_s6;
			zd_s7 <= zd_s6;
			r_s7 <= r_s6;
		end
	end

	// Linear depth divide; quotient at or above 2^32 is flagged up front
	logic [RAD_W-1:0] rem1;
	logic ovf1;
	logic v1_d;
	logic [DEPTH_W-1:0] q1_d;
	logic [ROOT_W+1:0] side1_d;

	assign rem1 = RAD_W'(num1_s7[NUM_W-1:DEPTH_W]);
	assign ovf1 = rem1 >= den1_s7;

	pdc_div #(.DW(RAD_W), .QW(DEPTH_W), .SW(ROOT_W + 2)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7),
		.in_rem(rem1), .in_den(den1_s7), .in_lo(num1_s7[DEPTH_W-1:0]),
		.in_side({r_s7, zd_s7, ovf1}),
		.out_valid(v1_d), .out_quot(q1_d), .out_side(side1_d)
	);

	// s8: clamp linear depth, distance to near plane
	logic v_s8, zd_s8, ovf_s8, zgtn_s8, zzero_s8;
	logic [DEPTH_W-1:0] z_s8, absd_s8;
	logic [ROOT_W-1:0] r_s8;
	logic [DEPTH_W-1:0] z8;

	assign z8 = (!mode_q && side1_d[0]) ? WORD_MAX : q1_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v1_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s8 <= z8;
			absd_s8 <= (z8 >= near_q) ? z8 - near_q : near_q - z8;
			zgtn_s8 <= z8 > near_q;
			zzero_s8 <= (q1_d == '0) && !side1_d[0];
			ovf_s8 <= side1_d[0];
			zd_s8 <= side1_d[1];
			r_s8 <= side1_d[ROOT_W+1:2];
		end
	end

	// s9: mode 0 depth times ray length; mode 1 both sides of the depth ratio
	logic v_s9, zd_s9, ovf_s9, zgtn_s9, zzero_s9;
	logic [RAD_W-1:0] pa_s9, pb_s9;
	logic [DEPTH_W-1:0] ma9, mb9;

	assign ma9 = mode_q ? far_q : z_s8;
	assign mb9 = mode_q ? absd_s8 : r_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s9 <= RAD_W'(ma9) * RAD_W'(mb9);
			pb_s9 <= RAD_W'(fmn_q) * RAD_W'(z_s8);
			zd_s9 <= zd_s8;
			ovf_s9 <= ovf_s8;
			zgtn_s9 <= zgtn_s8;
			zzero_s9 <= zzero_s8;
		end
	end

	// s10: final divide operands and the special-case result
	logic v_s10, fix_s10, fixsat_s10;
	logic [RAD_W-1:0] rem2_s10, den2_s10;
	logic [DEPTH_W-1:0] lo2_s10, fixval_s10;
	logic [RAD_W-1:0] n64;
	logic [NUM_W-1:0] n88;
	logic fix10, fixsat10;
	logic [DEPTH_W-1:0] fixval10;

	assign n64 = pa_s9 + RAD_W'({dls_q, 7'b0});
	assign n88 = {pa_s9, {NORM_W{1'b0}}} - NUM_W'(pa_s9) + NUM_W'(pb_s9 >> 1);

	always_comb begin
		fix10 = 1'b1;
		fixsat10 = 1'b1;
		fixval10 = DEPTH_W'(DEPTH_FULL);
		if (!mode_q) begin
			fix10 = zd_s9;
			fixval10 = WORD_MAX;
		end else if (zd_s9 || zzero_s9 || feqn) begin
			fixval10 = DEPTH_W'(DEPTH_FULL);
		end else if (ovf_s9) begin
			fixval10 = fgtn ? DEPTH_W'(DEPTH_FULL) : '0;
		end else if (pa_s9 == '0) begin
			fixval10 = '0;
			fixsat10 = 1'b0;
		end else if (zgtn_s9 != fgtn) begin
			fixval10 = '0;
		end else if (pa_s9 > pb_s9) begin
			fixval10 = DEPTH_W'(DEPTH_FULL);
		end else begin
			fix10 = 1'b0;
			fixsat10 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem2_s10 <= mode_q ? n88[NUM_W-1:NORM_W] : RAD_W'(n64[RAD_W-1:DEPTH_W]);
			lo2_s10 <= mode_q ? {n88[NORM_W-1:0], 8'b0} : n64[DEPTH_W-1:0];
			den2_s10 <= mode_q ? pb_s9 : RAD_W'({dls_q, 8'b0});
			fix_s10 <= fix10;
			fixval_s10 <= fixval10;
			fixsat_s10 <= fixsat10;
		end
	end

	// Final divide: ray distance in mode 0, scaled normalized depth in mode 1
	logic ovf2;
	logic v2_d;
	logic [DEPTH_W-1:0] q2_d;
	logic [DEPTH_W+2:0] side2_d;

	assign ovf2 = rem2_s10 >= den2_s10;

	pdc_div #(.DW(RAD_W), .QW(DEPTH_W), .SW(DEPTH_W + 3)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s10),
		.in_rem(rem2_s10), .in_den(den2_s10), .in_lo(lo2_s10),
		.in_side({fix_s10, fixval_s10, fixsat_s10, ovf2}),
		.out_valid(v2_d), .out_quot(q2_d), .out_side(side2_d)
	);

	// Select the result word
	logic [DEPTH_W-1:0] pval;
	logic psat;

	always_comb begin
		if (side2_d[DEPTH_W+2]) begin
			pval = side2_d[DEPTH_W+1:2];
			psat = side2_d[1];
		end else if (!mode_q) begin
			pval = side2_d[0] ? WORD_MAX : q2_d;
			psat = side2_d[0];
		end else begin
			pval = DEPTH_W'(q2_d[DEPTH_W-1:8]);
			psat = 1'b0;
		end
	end

	// Output register with skid stage
	logic out_v_q, out_sat_q, skid_sat_q;
	logic [DEPTH_W-1:0] out_val_q, skid_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (!out_v_q || result.ready)
				out_v_q <= v2_d;
			else if (v2_d)
				skid_v_q <= 1'b1;
		end else if (result.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_v_q || result.ready) begin
				out_val_q <= pval;
				out_sat_q <= psat;
			end else begin
				skid_val_q <= pval;
				skid_sat_q <= psat;
			end
		end else if (result.ready) begin
			out_val_q <= skid_val_q;
			out_sat_q <= skid_sat_q;
		end
	end

	assign result.valid = out_v_q;
	assign result.depth_out = out_val_q;
	assign result.saturated = out_sat_q;
endmodule
`default_nettype wire
